[rtl/core/analog_axis_autorange_scaler_assert.svh]
// Assertion macros shared by the RTL.
`ifndef ANALOG_AXIS_AUTORANGE_SCALER_ASSERT_SVH
`define ANALOG_AXIS_AUTORANGE_SCALER_ASSERT_SVH

// Same-cycle implication.
`define AAS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aas assertion failed");

// Next-cycle implication.
`define AAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aas assertion failed");

`endif

[rtl/core/aas_pkg.sv]
`timescale 1ns / 1ps
package aas_pkg;

  localparam logic [2:0] ACT_SAMPLE  = 3'd0;
  localparam logic [2:0] ACT_SETMIN  = 3'd1;
  localparam logic [2:0] ACT_SETMAX  = 3'd2;
  localparam logic [2:0] ACT_READ    = 3'd3;
  localparam logic [2:0] ACT_CLEAR   = 3'd4;
  localparam logic [2:0] ACT_RESTART = 3'd5;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_B0   = 3'd1;
  localparam logic [2:0] REG_B1   = 3'd2;
  localparam logic [2:0] REG_B2   = 3'd3;
  localparam logic [2:0] REG_A1   = 3'd4;
  localparam logic [2:0] REG_A2   = 3'd5;
  localparam logic [2:0] REG_GAIN = 3'd6;

  localparam logic signed [16:0] MIN_RESET = 17'sd65535;
  localparam logic signed [16:0] MAX_RESET = -17'sd65536;
  localparam logic signed [15:0] LIM_BAD   = -16'sd32768;
  localparam logic signed [16:0] CLIP_HI   = 17'sd32767;
  localparam logic signed [16:0] CLIP_LO   = -17'sd32767;
  localparam int DIV_BITS = 37;

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_LOAD, S_MB0, S_ACC, S_Y, S_MB1, S_MA1, S_MB2, S_MA2,
    S_FWR, S_RAW, S_RANGE, S_SCHK, S_MGAIN, S_NUM, S_DIV, S_FIN,
    S_SETLIM, S_CLR, S_RST, S_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_READ, OP_LOAD, OP_MB0, OP_ACC, OP_Y, OP_MB1, OP_MA1, OP_MB2,
    OP_MA2, OP_FWR, OP_RAW, OP_RANGE, OP_SCHK, OP_MGAIN, OP_NUM, OP_DIV,
    OP_FIN, OP_SETLIM, OP_CLR, OP_RST, OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic   take;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       ok_axis;
    logic       filt;
    logic       scale_ok;
    logic       div_done;
    logic       out_free;
  } dp_stat_t;

endpackage

[rtl/core/aas_in_if.sv]
`timescale 1ns / 1ps
interface aas_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [5:0]         axis;
  logic signed [16:0] sample;
  logic signed [15:0] limit_value;
  modport source (output valid, action, axis, sample, limit_value, input ready);
  modport sink (input valid, action, axis, sample, limit_value, output ready);
endinterface

[rtl/core/aas_out_if.sv]
`timescale 1ns / 1ps
interface aas_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         axis_out;
  logic signed [15:0] value;
  logic signed [16:0] limit_min;
  logic signed [16:0] limit_max;
  logic               status;
  modport source (output valid, axis_out, value, limit_min, limit_max, status,
                  input ready);
  modport sink (input valid, axis_out, value, limit_min, limit_max, status,
                output ready);
endinterface

[rtl/core/aas_cfg_if.sv]
`timescale 1ns / 1ps
interface aas_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/aas_datapath.sv]
`timescale 1ns / 1ps
module aas_datapath #(
  parameter int AXES           = 8,
  parameter int SETTLE_SAMPLES = 50
) (
  input  logic               clk,
  input  logic               rst,
  input  aas_pkg::dp_cmd_t   cmd,
  output aas_pkg::dp_stat_t  stat,
  input  logic [2:0]         action,
  input  logic [5:0]         axis,
  input  logic signed [16:0] sample,
  input  logic signed [15:0] limit_value,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         axis_out,
  output logic signed [15:0] value,
  output logic signed [16:0] limit_min,
  output logic signed [16:0] limit_max,
  output logic               status
);

  localparam int IW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int DB = aas_pkg::DIV_BITS;

  // configuration
  logic [2:0]         mode;
  logic signed [31:0] b0, b1, b2, a1, a2;
  logic [15:0]        gain;

  // item context
  logic [2:0]         act;
  logic [5:0]         ax;
  logic [IW-1:0]      idx;
  logic               ok;
  logic signed [16:0] x;
  logic signed [15:0] lim;

  // working registers
  logic signed [47:0] d1, d2;
  logic signed [16:0] mn, mx, v;
  logic signed [49:0] prod;
  logic signed [50:0] acc, t;
  logic signed [17:0] vm;
  logic [15:0]        rng;
  logic               scale_ok;
  logic               neg;
  logic [DB-1:0]      dvd;
  logic [15:0]        rem;
  logic [5:0]         cnt;
  logic [7:0]         settle;

  // per-axis stores
  logic [95:0]     fmem [AXES];
  logic [33:0]     lmem [AXES];
  logic [AXES-1:0] fvalid, lvalid;
  logic [95:0]     frd;
  logic [33:0]     lrd;
  logic            fv_rd, lv_rd;

  logic ok_in;
  assign ok_in = {1'b0, axis} < 7'(AXES);

  // shared multiplier
  logic signed [17:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [49:0] mul_p;
  always_comb begin
    case (cmd.op)
      aas_pkg::OP_MB1:   begin mul_a = 18'(x); mul_b = b1; end
      aas_pkg::OP_MA1:   begin mul_a = 18'(v); mul_b = a1; end
      aas_pkg::OP_MB2:   begin mul_a = 18'(x); mul_b = b2; end
      aas_pkg::OP_MA2:   begin mul_a = 18'(v); mul_b = a2; end
      aas_pkg::OP_MGAIN: begin mul_a = vm; mul_b = $signed({16'd0, gain}); end
      default:           begin mul_a = 18'(x); mul_b = b0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // filter output: truncate toward zero, then saturate
  logic [50:0]        acc_mag;
  logic [22:0]        acc_q;
  logic signed [16:0] y_c;
  always_comb begin
    acc_mag = acc[50] ? 51'(-acc) : 51'(acc);
    acc_q   = acc_mag[50:28];
    if (!acc[50]) begin
      y_c = (acc_q > 23'd65535) ? 17'sd65535 : $signed(acc_q[16:0]);
    end else begin
      y_c = (acc_q > 23'd65536) ? -17'sd65536 : $signed(~acc_q[16:0] + 17'd1);
    end
  end

  logic [47:0] d2_c;
  assign d2_c = t[47:0] - prod[47:0];

  // autorange
  logic               upd;
  logic signed [16:0] nmn, nmx;
  assign upd = mode[0] && ((settle > 8'(SETTLE_SAMPLES)) || !mode[1]);
  assign nmx = (v > mx) ? v : mx;
  assign nmn = (v < mn) ? v : mn;

  logic signed [17:0] r_c;
  assign r_c = 18'(mx) - 18'(mn);

  logic signed [50:0] num_c, num_mag;
  assign num_c   = (51'(prod) <<< 16) - 51'(prod);
  assign num_mag = num_c[50] ? -num_c : num_c;

  logic [16:0] trial;
  logic        ge;
  assign trial = {rem, dvd[DB-1]};
  assign ge    = trial >= {1'b0, rng};

  logic signed [38:0] qs, sv;
  assign qs = neg ? -$signed({2'b00, dvd}) : $signed({2'b00, dvd});
  assign sv = qs - 39'sd32767;

  logic               lim_ok;
  logic signed [16:0] lim17;
  assign lim_ok = ok && (lim != aas_pkg::LIM_BAD);
  assign lim17  = 17'(lim);

  logic               out_free, out_load;
  logic signed [16:0] vclip;
  logic               st;
  assign out_free = !out_valid || out_ready;
  assign out_load = (cmd.op == aas_pkg::OP_OUT) && out_free;
  assign vclip = (v > aas_pkg::CLIP_HI) ? aas_pkg::CLIP_HI :
                 (v < aas_pkg::CLIP_LO) ? aas_pkg::CLIP_LO : v;
  assign st = (act > aas_pkg::ACT_RESTART) ||
              (!ok && (act <= aas_pkg::ACT_READ)) ||
              (((act == aas_pkg::ACT_SETMIN) || (act == aas_pkg::ACT_SETMAX)) &&
               (lim == aas_pkg::LIM_BAD));

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 3'd0;
      b0        <= 32'sd268435456;
      b1        <= '0;
      b2        <= '0;
      a1        <= '0;
      a2        <= '0;
      gain      <= 16'd16384;
      fvalid    <= '0;
      lvalid    <= '0;
      settle    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          aas_pkg::REG_MODE: mode <= cfg_data[2:0];
          aas_pkg::REG_B0:   b0 <= $signed(cfg_data);
          aas_pkg::REG_B1:   b1 <= $signed(cfg_data);
          aas_pkg::REG_B2:   b2 <= $signed(cfg_data);
          aas_pkg::REG_A1:   a1 <= $signed(cfg_data);
          aas_pkg::REG_A2:   a2 <= $signed(cfg_data);
          aas_pkg::REG_GAIN: gain <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (cmd.op)
        aas_pkg::OP_FWR: begin
          fvalid[idx] <= 1'b1;
          if (settle <= 8'(SETTLE_SAMPLES)) settle <= settle + 8'd1;
        end
        aas_pkg::OP_RANGE:  if (upd) lvalid[idx] <= 1'b1;
        aas_pkg::OP_SETLIM: if (lim_ok) lvalid[idx] <= 1'b1;
        aas_pkg::OP_CLR:    lvalid <= '0;
        aas_pkg::OP_RST: begin
          fvalid <= '0;
          settle <= '0;
        end
        default: ;
      endcase
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // stores
  always_ff @(posedge clk) begin
    if (cmd.op == aas_pkg::OP_READ) begin
      frd   <= fmem[idx];
      lrd   <= lmem[idx];
      fv_rd <= fvalid[idx];
      lv_rd <= lvalid[idx];
    end
    if (cmd.op == aas_pkg::OP_FWR) fmem[idx] <= {d1, d2_c};
    if ((cmd.op == aas_pkg::OP_RANGE) && upd) lmem[idx] <= {nmn, nmx};
    if ((cmd.op == aas_pkg::OP_SETLIM) && lim_ok) begin
      if (act == aas_pkg::ACT_SETMIN) lmem[idx] <= {lim17, mx};
      else lmem[idx] <= {mn, lim17};
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      act <= action;
      ax  <= axis;
      ok  <= ok_in;
      idx <= ok_in ? axis[IW-1:0] : '0;
      x   <= sample;
      lim <= limit_value;
    end
    case (cmd.op)
      aas_pkg::OP_LOAD: begin
        d1 <= fv_rd ? $signed(frd[95:48]) : '0;
        d2 <= fv_rd ? $signed(frd[47:0]) : '0;
        mn <= lv_rd ? $signed(lrd[33:17]) : aas_pkg::MIN_RESET;
        mx <= lv_rd ? $signed(lrd[16:0]) : aas_pkg::MAX_RESET;
      end
      aas_pkg::OP_MB0: prod <= mul_p;
      aas_pkg::OP_ACC: acc <= 51'(prod) + 51'(d1);
      aas_pkg::OP_Y:   v <= y_c;
      aas_pkg::OP_MB1: prod <= mul_p;
      aas_pkg::OP_MA1: begin
        t    <= 51'(prod) + 51'(d2);
        prod <= mul_p;
      end
      aas_pkg::OP_MB2: begin
        d1   <= $signed(t[47:0] - prod[47:0]);
        prod <= mul_p;
      end
      aas_pkg::OP_MA2: begin
        t    <= 51'(prod);
        prod <= mul_p;
      end
      aas_pkg::OP_RAW: v <= x;
      aas_pkg::OP_RANGE: begin
        if (upd) begin
          mn <= nmn;
          mx <= nmx;
        end
      end
      aas_pkg::OP_SCHK: begin
        scale_ok <= (r_c > 18'sd1) && (r_c <= 18'sd65535) && !mode[2];
        rng      <= r_c[15:0];
        vm       <= 18'(v) - 18'(mn);
      end
      aas_pkg::OP_MGAIN: prod <= mul_p;
      aas_pkg::OP_NUM: begin
        neg <= num_c[50];
        dvd <= num_mag[50:14];
        rem <= '0;
        cnt <= '0;
      end
      aas_pkg::OP_DIV: begin
        rem <= ge ? 16'(trial - {1'b0, rng}) : trial[15:0];
        dvd <= {dvd[DB-2:0], ge};
        cnt <= cnt + 6'd1;
      end
      aas_pkg::OP_FIN: begin
        if (sv > 39'sd32767) v <= aas_pkg::CLIP_HI;
        else if (sv < -39'sd32767) v <= aas_pkg::CLIP_LO;
        else v <= 17'(sv);
      end
      aas_pkg::OP_SETLIM: begin
        if (lim_ok) begin
          if (act == aas_pkg::ACT_SETMIN) mn <= lim17;
          else mx <= lim17;
        end
      end
      aas_pkg::OP_CLR: begin
        mn <= aas_pkg::MIN_RESET;
        mx <= aas_pkg::MAX_RESET;
      end
      default: ;
    endcase
    if (out_load) begin
      axis_out  <= ax;
      value     <= ((act == aas_pkg::ACT_SAMPLE) && ok) ? 16'(vclip) : '0;
      limit_min <= ok ? mn : '0;
      limit_max <= ok ? mx : '0;
      status    <= st;
    end
  end

  always_comb begin
    stat.act      = act;
    stat.ok_axis  = ok;
    stat.filt     = mode[1];
    stat.scale_ok = scale_ok;
    stat.div_done = cnt == 6'(DB - 1);
    stat.out_free = out_free;
  end

endmodule

[rtl/core/aas_ctrl.sv]
`timescale 1ns / 1ps
`include "analog_axis_autorange_scaler_assert.svh"
module aas_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  aas_pkg::dp_stat_t stat,
  output aas_pkg::dp_cmd_t  cmd
);

  aas_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= aas_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.take   = 1'b0;
    cmd.op     = aas_pkg::OP_NONE;
    in_ready   = 1'b0;
    case (state)
      aas_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid) state_next = aas_pkg::S_READ;
      end
      aas_pkg::S_READ: begin
        cmd.op = aas_pkg::OP_READ;
        state_next = aas_pkg::S_LOAD;
      end
      aas_pkg::S_LOAD: begin
        cmd.op = aas_pkg::OP_LOAD;
        case (stat.act)
          aas_pkg::ACT_SAMPLE: begin
            if (!stat.ok_axis) state_next = aas_pkg::S_OUT;
            else if (stat.filt) state_next = aas_pkg::S_MB0;
            else state_next = aas_pkg::S_RAW;
          end
          aas_pkg::ACT_SETMIN,
          aas_pkg::ACT_SETMAX:  state_next = aas_pkg::S_SETLIM;
          aas_pkg::ACT_CLEAR:   state_next = aas_pkg::S_CLR;
          aas_pkg::ACT_RESTART: state_next = aas_pkg::S_RST;
          default:              state_next = aas_pkg::S_OUT;
        endcase
      end
      aas_pkg::S_MB0: begin cmd.op = aas_pkg::OP_MB0; state_next = aas_pkg::S_ACC; end
      aas_pkg::S_ACC: begin cmd.op = aas_pkg::OP_ACC; state_next = aas_pkg::S_Y; end
      aas_pkg::S_Y:   begin cmd.op = aas_pkg::OP_Y;   state_next = aas_pkg::S_MB1; end
      aas_pkg::S_MB1: begin cmd.op = aas_pkg::OP_MB1; state_next = aas_pkg::S_MA1; end
      aas_pkg::S_MA1: begin cmd.op = aas_pkg::OP_MA1; state_next = aas_pkg::S_MB2; end
      aas_pkg::S_MB2: begin cmd.op = aas_pkg::OP_MB2; state_next = aas_pkg::S_MA2; end
      aas_pkg::S_MA2: begin cmd.op = aas_pkg::OP_MA2; state_next = aas_pkg::S_FWR; end
      aas_pkg::S_FWR: begin cmd.op = aas_pkg::OP_FWR; state_next = aas_pkg::S_RANGE; end
      aas_pkg::S_RAW: begin cmd.op = aas_pkg::OP_RAW; state_next = aas_pkg::S_RANGE; end
      aas_pkg::S_RANGE: begin
        cmd.op = aas_pkg::OP_RANGE;
        state_next = aas_pkg::S_SCHK;
      end
      aas_pkg::S_SCHK: begin
        cmd.op = aas_pkg::OP_SCHK;
        state_next = aas_pkg::S_MGAIN;
      end
      aas_pkg::S_MGAIN: begin
        // skip the division when the range is unusable
        if (stat.scale_ok) begin
          cmd.op = aas_pkg::OP_MGAIN;
          state_next = aas_pkg::S_NUM;
        end else begin
          state_next = aas_pkg::S_OUT;
        end
      end
      aas_pkg::S_NUM: begin
        cmd.op = aas_pkg::OP_NUM;
        state_next = aas_pkg::S_DIV;
      end
      aas_pkg::S_DIV: begin
        cmd.op = aas_pkg::OP_DIV;
        if (stat.div_done) state_next = aas_pkg::S_FIN;
      end
      aas_pkg::S_FIN: begin
        cmd.op = aas_pkg::OP_FIN;
        state_next = aas_pkg::S_OUT;
      end
      aas_pkg::S_SETLIM: begin
        cmd.op = aas_pkg::OP_SETLIM;
        state_next = aas_pkg::S_OUT;
      end
      aas_pkg::S_CLR: begin cmd.op = aas_pkg::OP_CLR; state_next = aas_pkg::S_OUT; end
      aas_pkg::S_RST: begin cmd.op = aas_pkg::OP_RST; state_next = aas_pkg::S_OUT; end
      aas_pkg::S_OUT: begin
        cmd.op = aas_pkg::OP_OUT;
        if (stat.out_free) state_next = aas_pkg::S_IDLE;
      end
      default: state_next = aas_pkg::S_IDLE;
    endcase
  end

  `AAS_ASSERT_NEXT(a_accept_reads, clk, rst, in_valid && in_ready, state == aas_pkg::S_READ)
  `AAS_ASSERT_NEXT(a_div_exit, clk, rst, (state == aas_pkg::S_DIV) && stat.div_done, state == aas_pkg::S_FIN)
  `AAS_ASSERT_NEXT(a_out_done, clk, rst, (state == aas_pkg::S_OUT) && stat.out_free, state == aas_pkg::S_IDLE)
  `AAS_ASSERT_NOW(a_take_idle, clk, rst, cmd.take, (state == aas_pkg::S_IDLE) && in_valid)

endmodule

[rtl/core/analog_axis_autorange_scaler.sv]
// Analog axis autorange scaler. Each input item names an action and an axis;
// every item yields exactly one result item. Items are handled one at a time.
// Read limits, an unknown action or a sample on a bad axis go straight from
// loading to the result; set, clear and restart pass one step first; a sample
// is filtered or taken raw, then goes through the autorange step, and a scaled
// sample also passes through the bit-serial range divider. The input is ready
// again in the cycle in which the loaded result goes valid, and a result held
// by the receiver stalls the sequencer until it is taken. The biquad shares one 18x32 multiplier over five
// products. Per-axis filter state and limits live in small memories with
// per-entry valid bits, so reset, "clear limits" and "restart filters" take
// effect at once with no clearing pass.
// Configuration writes are always accepted and must only occur while idle.
`timescale 1ns / 1ps
module analog_axis_autorange_scaler #(
  parameter int AXES           = 8,
  parameter int SETTLE_SAMPLES = 50
) (
  input logic       clk,
  input logic       rst,
  aas_in_if.sink    samples,
  aas_out_if.source results,
  aas_cfg_if.sink   cfg
);

  aas_pkg::dp_cmd_t  cmd;
  aas_pkg::dp_stat_t stat;

  // register writes never stall
  assign cfg.ready = 1'b1;

  // sequencer: walks the item through filter, autorange, scaling, limit and restart steps
  aas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: config registers, per-axis stores, multiplier, divider, output register
  aas_datapath #(
    .AXES           (AXES),
    .SETTLE_SAMPLES (SETTLE_SAMPLES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .action      (samples.action),
    .axis        (samples.axis),
    .sample      (samples.sample),
    .limit_value (samples.limit_value),
    .cfg_valid   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .axis_out    (results.axis_out),
    .value       (results.value),
    .limit_min   (results.limit_min),
    .limit_max   (results.limit_max),
    .status      (results.status)
  );

endmodule
